// File: rtl/cbct_pkg.sv
// ----------------------------------------------------------------------------
// cbct_pkg
// Types and constants shared by the color blob centroid tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package cbct_pkg;
   localparam int SUM_W = 30;
   localparam int CNT_W = 21;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_HUE_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HUE_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SAT_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SAT_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VAL_MIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_VAL_MAX = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DISCOUNT = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y,
      ST_DIV_F,
      ST_BLEND,
      ST_DIV_AZ,
      ST_DIV_EL,
      ST_OUT
   } state_type;

   // divider operand select
   typedef enum logic [2:0] {
      DSEL_X,
      DSEL_Y,
      DSEL_F,
      DSEL_AZ,
      DSEL_EL
   } dsel_type;

   typedef struct packed {
      logic     pix_take;
      logic     div_start;
      dsel_type div_sel;
      logic     div_store;
      logic     blend_en;
      logic     out_load;
      logic     acc_clear;
   } cmd_type;

   typedef struct packed {
      logic frame_end;
      logic div_done;
   } sts_type;
endpackage
`default_nettype wire

// File: rtl/cbct_if.sv
// ----------------------------------------------------------------------------
// cbct_req_if / cbct_rsp_if
// Valid/ready channels for pixels and tracking results.
// ----------------------------------------------------------------------------
`default_nettype none
interface cbct_req_if;
   logic       valid;
   logic       ready;
   logic [9:0] column;
   logic [9:0] row;
   logic [7:0] hue;
   logic [7:0] sat;
   logic [7:0] val;
   logic       last_of_frame;
   modport source (output valid, column, row, hue, sat, val, last_of_frame, input ready);
   modport sink (input valid, column, row, hue, sat, val, last_of_frame, output ready);
endinterface

interface cbct_rsp_if;
   logic               valid;
   logic               ready;
   logic        [15:0] center_x;
   logic        [15:0] center_y;
   logic        [15:0] strength;
   logic signed [15:0] azimuth;
   logic signed [15:0] elevation;
   logic               empty_frame;
   modport source (output valid, center_x, center_y, strength, azimuth, elevation,
                   empty_frame, input ready);
   modport sink (input valid, center_x, center_y, strength, azimuth, elevation,
                 empty_frame, output ready);
endinterface
`default_nettype wire

// File: rtl/cbct_ctrl.sv
// ----------------------------------------------------------------------------
// cbct_ctrl
// Sequencer for pixel intake and the frame-end division and blend steps.
// ----------------------------------------------------------------------------
`default_nettype none
module cbct_ctrl
   import cbct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire logic    rsp_busy,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   state_type state_ff, state_in;
   logic      started_ff, started_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
      end
   end

   function automatic state_type next_div(state_type s);
      case (s)
         ST_DIV_X:  return ST_DIV_Y;
         ST_DIV_Y:  return ST_DIV_F;
         ST_DIV_F:  return ST_BLEND;
         ST_DIV_AZ: return ST_DIV_EL;
         ST_DIV_EL: return ST_OUT;
         default:   return ST_IDLE;
      endcase
   endfunction

   always_comb begin
      state_in   = state_ff;
      started_in = started_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sts.frame_end) begin
               state_in   = ST_DIV_X;
               started_in = 1'b0;
            end
         end
         ST_DIV_X, ST_DIV_Y, ST_DIV_F, ST_DIV_AZ, ST_DIV_EL: begin
            if (!started_ff) started_in = 1'b1;
            else if (sts.div_done) begin
               state_in   = next_div(state_ff);
               started_in = 1'b0;
            end
         end
         ST_BLEND: begin
            state_in   = ST_DIV_AZ;
            started_in = 1'b0;
         end
         ST_OUT: begin
            if (!rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.div_sel   = DSEL_X;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = !sts.frame_end;
            cmd.pix_take = req_valid && !sts.frame_end;
         end
         ST_DIV_X, ST_DIV_Y, ST_DIV_F, ST_DIV_AZ, ST_DIV_EL: begin
            case (state_ff)
               ST_DIV_Y:  cmd.div_sel = DSEL_Y;
               ST_DIV_F:  cmd.div_sel = DSEL_F;
               ST_DIV_AZ: cmd.div_sel = DSEL_AZ;
               ST_DIV_EL: cmd.div_sel = DSEL_EL;
               default:   cmd.div_sel = DSEL_X;
            endcase
            cmd.div_start = !started_ff;
            cmd.div_store = started_ff && sts.div_done;
         end
         ST_BLEND: cmd.blend_en = 1'b1;
         ST_OUT: begin
            if (!rsp_busy) begin
               cmd.out_load  = 1'b1;
               cmd.acc_clear = 1'b1;
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/cbct_dp.sv
// ----------------------------------------------------------------------------
// cbct_dp
// Match, accumulate, shared restoring divider, blend and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module cbct_dp
   import cbct_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   cbct_req_if.sink                   req,
   cbct_rsp_if.source                 rsp,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   output logic                       rsp_busy
);
   localparam int NUM_W = 48;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);
   localparam int W_W = $clog2(MAX_WIDTH + 1);
   localparam int H_W = $clog2(MAX_HEIGHT + 1);
   localparam int AREA_W = W_W + H_W;

   logic [7:0]  hue_min_ff, hue_max_ff, sat_min_ff, sat_max_ff, val_min_ff, val_max_ff;
   logic [15:0] discount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_min_ff <= '0; hue_max_ff <= '1;
         sat_min_ff <= '0; sat_max_ff <= '1;
         val_min_ff <= '0; val_max_ff <= '1;
         discount_ff <= 16'h8000;
      end else if (csr_write) begin
         case (csr_index)
            REG_HUE_MIN:  hue_min_ff  <= csr_data[7:0];
            REG_HUE_MAX:  hue_max_ff  <= csr_data[7:0];
            REG_SAT_MIN:  sat_min_ff  <= csr_data[7:0];
            REG_SAT_MAX:  sat_max_ff  <= csr_data[7:0];
            REG_VAL_MIN:  val_min_ff  <= csr_data[7:0];
            REG_VAL_MAX:  val_max_ff  <= csr_data[7:0];
            REG_DISCOUNT: discount_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic match;
   assign match = req.hue >= hue_min_ff && req.hue <= hue_max_ff &&
                  req.sat >= sat_min_ff && req.sat <= sat_max_ff &&
                  req.val >= val_min_ff && req.val <= val_max_ff;

   // accumulate, including the frame-end pixel when it is captured
   logic [SUM_W-1:0] sum_x_ff, sum_y_ff;
   logic [CNT_W-1:0] count_ff;
   logic             pend_ff;
   logic [W_W-1:0]   width_ff;
   logic [H_W-1:0]   height_ff;
   logic             take;
   logic [SUM_W:0]   sx_add, sy_add;
   logic [CNT_W:0]   c_add;
   logic [10:0]      w_raw, h_raw;

   assign take   = cmd.pix_take || (req.valid && req.ready);
   assign sx_add = {1'b0, sum_x_ff} + (SUM_W+1)'(req.column);
   assign sy_add = {1'b0, sum_y_ff} + (SUM_W+1)'(req.row);
   assign c_add  = {1'b0, count_ff} + (CNT_W+1)'(1);
   assign w_raw  = {1'b0, req.column} + 11'd1;
   assign h_raw  = {1'b0, req.row} + 11'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff <= '0; sum_y_ff <= '0; count_ff <= '0; pend_ff <= 1'b0;
      end else begin
         if (cmd.acc_clear) begin
            sum_x_ff <= '0; sum_y_ff <= '0; count_ff <= '0; pend_ff <= 1'b0;
         end
         if (take && req.valid && !pend_ff) begin
            if (match) begin
               sum_x_ff <= sx_add[SUM_W] ? '1 : sx_add[SUM_W-1:0];
               sum_y_ff <= sy_add[SUM_W] ? '1 : sy_add[SUM_W-1:0];
               count_ff <= c_add[CNT_W] ? '1 : c_add[CNT_W-1:0];
            end
            if (req.last_of_frame) begin
               pend_ff   <= 1'b1;
               width_ff  <= (32'(w_raw) > 32'(MAX_WIDTH)) ? W_W'(MAX_WIDTH) : W_W'(w_raw);
               height_ff <= (32'(h_raw) > 32'(MAX_HEIGHT)) ? H_W'(MAX_HEIGHT) : H_W'(h_raw);
            end
         end
      end
   end
   assign sts.frame_end = pend_ff;

   // area multiply registered while first division runs
   logic [AREA_W-1:0] area_ff;
   always_ff @(posedge clock) area_ff <= AREA_W'(width_ff) * AREA_W'(height_ff);

   // smoothed state
   logic [15:0] sm_x_ff, sm_y_ff, sm_s_ff;
   logic [15:0] fx_ff, fy_ff, fs_ff;
   logic [15:0] az_ff, el_ff;

   // divider: restoring, one quotient bit per cycle
   logic [NUM_W-1:0]     d_num, q_ff;
   logic [AREA_W+8:0]    d_den;
   logic [AREA_W+8:0]    den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 d_neg;
   logic [AREA_W+9:0]    r_try;
   logic [AREA_W+10:0]   r_sh;
   logic signed [17:0]   off_x, off_y;

   assign off_x = $signed({2'b0, sm_x_ff}) - $signed(18'(64 * (width_ff / 2)));
   assign off_y = $signed({2'b0, sm_y_ff}) - $signed(18'(64 * (height_ff / 2)));

   always_comb begin
      d_num = '0; d_den = '0; d_neg = 1'b0;
      case (cmd.div_sel)
         DSEL_X: begin
            d_num = NUM_W'({sum_x_ff, 6'd0}) + NUM_W'(count_ff >> 1);
            d_den = (AREA_W+9)'(count_ff);
         end
         DSEL_Y: begin
            d_num = NUM_W'({sum_y_ff, 6'd0}) + NUM_W'(count_ff >> 1);
            d_den = (AREA_W+9)'(count_ff);
         end
         DSEL_F: begin
            d_num = NUM_W'({count_ff, 16'd0}) + NUM_W'(area_ff >> 1);
            d_den = (AREA_W+9)'(area_ff);
         end
         // ceil of magnitude for negatives: (|n| + den - 1)
         DSEL_AZ: begin
            d_neg = off_x < 0;
            d_num = d_neg ? NUM_W'({18'(-off_x), 9'd0}) + NUM_W'(width_ff) - NUM_W'(1)
                          : NUM_W'({off_x[16:0], 9'd0});
            d_den = (AREA_W+9)'(width_ff);
         end
         DSEL_EL: begin
            d_neg = off_y < 0;
            d_num = d_neg ? NUM_W'({18'(-off_y), 9'd0}) + NUM_W'(height_ff) - NUM_W'(1)
                          : NUM_W'({off_y[16:0], 9'd0});
            d_den = (AREA_W+9)'(height_ff);
         end
         default: ;
      endcase
   end

   logic [AREA_W+9:0] rem_ff;
   assign r_sh  = {rem_ff, q_ff[NUM_W-1]};
   assign r_try = r_sh[AREA_W+9:0] - {1'b0, den_ff};
   assign sts.div_done = busy_ff && cnt_ff == '0;
   logic neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else if (cmd.div_start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(NUM_W);
         q_ff    <= d_num;
         den_ff  <= d_den;
         rem_ff  <= '0;
         neg_ff  <= d_neg;
      end else if (busy_ff && cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (r_sh[AREA_W+10] || r_sh[AREA_W+9:0] >= {1'b0, den_ff}) begin
            rem_ff <= r_try;
            q_ff   <= {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= r_sh[AREA_W+9:0];
            q_ff   <= {q_ff[NUM_W-2:0], 1'b0};
         end
      end else if (sts.div_done) begin
         busy_ff <= 1'b0;
      end
   end

   logic [15:0] q_sat;
   assign q_sat = (q_ff[NUM_W-1:16] != '0) ? 16'hFFFF : q_ff[15:0];

   // signed Q1.15 saturation of a magnitude with sign
   logic [15:0] q_off;
   always_comb begin
      if (!neg_ff) q_off = (q_ff > NUM_W'(32767)) ? 16'h7FFF : q_ff[15:0];
      else q_off = (q_ff > NUM_W'(32768)) ? 16'h8000 : 16'(-q_ff[15:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         case (cmd.div_sel)
            DSEL_X:  fx_ff <= q_sat;
            DSEL_Y:  fy_ff <= q_sat;
            DSEL_F:  fs_ff <= q_sat;
            DSEL_AZ: az_ff <= q_off;
            DSEL_EL: el_ff <= q_off;
            default: ;
         endcase
      end
   end

   function automatic logic [15:0] blend(logic [15:0] fresh, logic [15:0] old,
                                         logic [15:0] d);
      logic [33:0] v;
      v = 34'(fresh) * (34'(17'h10000) - 34'(d)) + 34'(old) * 34'(d) + 34'd32768;
      return v[31:16];
   endfunction

   logic empty;
   assign empty = count_ff == '0;
   always_ff @(posedge clock) begin
      if (reset) begin
         sm_x_ff <= '0; sm_y_ff <= '0; sm_s_ff <= '0;
      end else if (cmd.blend_en) begin
         if (!empty) begin
            sm_x_ff <= blend(fx_ff, sm_x_ff, discount_ff);
            sm_y_ff <= blend(fy_ff, sm_y_ff, discount_ff);
         end
         sm_s_ff <= blend(fs_ff, sm_s_ff, discount_ff);
      end
   end

   // output register
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp.center_x    <= sm_x_ff;
         rsp.center_y    <= sm_y_ff;
         rsp.strength    <= sm_s_ff;
         rsp.azimuth     <= az_ff;
         rsp.elevation   <= el_ff;
         rsp.empty_frame <= empty;
      end
   end
   assign rsp.valid = rsp_valid_ff;
   assign rsp_busy  = rsp_valid_ff && !rsp.ready;
endmodule
`default_nettype wire

// File: rtl/color_blob_centroid_tracker.sv
// ----------------------------------------------------------------------------
// color_blob_centroid_tracker
// HSV window match, centroid sums, frame-end smoothing and angle offsets.
//
//   channel  dir  handshake
//   req      in   valid/ready, pixel per transfer
//   rsp      out  valid/ready, one result per frame
//   csr      in   write enable, index, data
//
// Ordinary pixels are accepted back to back. The frame-end pixel starts five
// serial divisions on one shared restoring divider, each a load, one step for
// each of the 48 quotient bits and a store, plus a blend step; the result is
// then registered, later while the previous result still waits. No pixel is
// taken meanwhile; the next one can be taken as soon as the result is
// registered. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module color_blob_centroid_tracker
   import cbct_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   cbct_req_if.sink                   req,
   cbct_rsp_if.source                 rsp
);
   cmd_type cmd;
   sts_type sts;
   logic    rsp_busy;

   cbct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_busy  (rsp_busy),
      .sts       (sts),
      .cmd       (cmd)
   );

   cbct_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req       (req),
      .rsp       (rsp),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_busy  (rsp_busy)
   );
endmodule
`default_nettype wire
